[sv/chd_pkg.sv]
// Shared types and constants of the canonical Huffman decoder.
package chd_pkg;

   // Field widths of the request and response words.
   localparam int LEN_W  = 4;
   localparam int SYM_W  = 9;
   localparam int BITS_W = 4;
   localparam int WIN_W  = 16;

   // Code lengths run from 1 to 15; index 0 means an unused symbol.
   localparam int NUM_LEN = 1 << LEN_W;
   localparam int MAX_LEN = 15;

   // Limit saturation value and the mask applied to the stream peek.
   localparam logic [WIN_W-1:0] LIMIT_SAT = 16'hFFFF;
   localparam logic [WIN_W-1:0] PEEK_MASK = 16'hFFFE;

   // Request kinds.
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // Response kinds.
   localparam logic KIND_SYMBOL = 1'b0;
   localparam logic KIND_BUILD  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_wr;
      logic peek_ld;
      logic hist_clr;
      logic scan_clr;
      logic hist_run;
      logic lim_start;
      logic lim_run;
      logic fill_run;
      logic dec_cmp;
      logic dec_ofs;
      logic dec_idx;
      logic out_sym;
      logic out_build;
   } chd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic lim_done;
      logic out_free;
   } chd_status_type;

endpackage

[sv/chd_controller.sv]
// Sequencing state machine of the canonical Huffman decoder.
module chd_controller import chd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           req_type,
   input  logic           req_last_length,
   input  chd_status_type status,
   output chd_cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_HIST      = 9'b000000010,
      ST_LIMITS    = 9'b000000100,
      ST_FILL      = 9'b000001000,
      ST_BUILD_OUT = 9'b000010000,
      ST_DEC_CMP   = 9'b000100000,
      ST_DEC_OFS   = 9'b001000000,
      ST_DEC_IDX   = 9'b010000000,
      ST_DEC_OUT   = 9'b100000000
   } chd_state_type;

   chd_state_type state_ff;
   chd_state_type state_in;
   logic          req_accept;

   // Words are taken only while no other work is in flight.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_type == REQ_DECODE) begin
                  cmd.peek_ld = 1'b1;
                  state_in    = ST_DEC_CMP;
               end else begin
                  cmd.load_wr = 1'b1;
                  if (req_last_length) begin
                     cmd.hist_clr = 1'b1;
                     cmd.scan_clr = 1'b1;
                     state_in     = ST_HIST;
                  end
               end
            end
         end
         ST_HIST: begin
            cmd.hist_run = 1'b1;
            if (status.scan_done) begin
               cmd.lim_start = 1'b1;
               state_in      = ST_LIMITS;
            end
         end
         ST_LIMITS: begin
            cmd.lim_run = 1'b1;
            if (status.lim_done) begin
               cmd.scan_clr = 1'b1;
               state_in     = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_BUILD_OUT;
            end
         end
         ST_BUILD_OUT: begin
            if (status.out_free) begin
               cmd.out_build = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DEC_CMP: begin
            cmd.dec_cmp = 1'b1;
            state_in    = ST_DEC_OFS;
         end
         ST_DEC_OFS: begin
            cmd.dec_ofs = 1'b1;
            state_in    = ST_DEC_IDX;
         end
         ST_DEC_IDX: begin
            cmd.dec_idx = 1'b1;
            state_in    = ST_DEC_OUT;
         end
         ST_DEC_OUT: begin
            if (status.out_free) begin
               cmd.out_sym = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/chd_datapath.sv]
// Length store, table build datapath, symbol store and decode path.
module chd_datapath import chd_pkg::*; #(
   parameter int MAX_SYMBOLS = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  chd_cmd_type       cmd,
   output chd_status_type    status,
   input  logic [LEN_W-1:0]  req_code_length,
   input  logic [WIN_W-1:0]  req_bit_window,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic              rsp_result_kind,
   output logic [SYM_W-1:0]  rsp_symbol,
   output logic [BITS_W-1:0] rsp_code_bits
);

   localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
   localparam int ADDR_W = $clog2(MAX_SYMBOLS);
   localparam int ACC_W  = CNT_W + 16;
   localparam int WIDE_W = ACC_W + MAX_LEN - 1;
   localparam int OFS_W  = WIN_W - 1;
   localparam int IDX_W  = ((CNT_W > OFS_W) ? CNT_W : OFS_W) + 1;
   localparam int SHF_W  = $clog2(WIN_W + 1);

   // Memories.
   logic [LEN_W-1:0] len_mem [MAX_SYMBOLS];
   logic [SYM_W-1:0] sym_mem [MAX_SYMBOLS];

   // Control registers.
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  table_size_ff, table_size_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [LEN_W-1:0]  lstep_ff, lstep_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Table registers.
   logic [CNT_W-1:0]  hist_ff [NUM_LEN];
   logic [CNT_W-1:0]  hist_in [NUM_LEN];
   logic [WIN_W-1:0]  limit_ff [NUM_LEN];
   logic [WIN_W-1:0]  limit_in [NUM_LEN];
   logic [CNT_W-1:0]  base_ff [NUM_LEN];
   logic [CNT_W-1:0]  base_in [NUM_LEN];
   logic [CNT_W-1:0]  next_pos_ff [NUM_LEN];
   logic [CNT_W-1:0]  next_pos_in [NUM_LEN];

   // Payload registers.
   logic [LEN_W-1:0]  len_rd_ff;
   logic [CNT_W-1:0]  sidx_ff;
   logic [SYM_W-1:0]  sym_rd_ff;
   logic [WIN_W-1:0]  peek_ff;
   logic [BITS_W-1:0] bits_ff;
   logic [OFS_W-1:0]  ofs_ff;
   logic              rsp_kind_ff;
   logic [SYM_W-1:0]  rsp_symbol_ff;
   logic [BITS_W-1:0] rsp_bits_ff;

   // Combinational helpers.
   logic              count_room;
   logic              scan_run;
   logic              scan_issue;
   logic [ADDR_W-1:0] rd_addr;
   logic              fill_wr;
   logic              sym_we;
   logic [ADDR_W-1:0] sym_wa;
   logic [SYM_W-1:0]  sym_wd;
   logic [ACC_W-1:0]  acc_sum;
   logic [ACC_W-1:0]  acc_next;
   logic [WIDE_W-1:0] lim_wide;
   logic [WIN_W-1:0]  lim_val;
   logic [CNT_W-1:0]  base_new;
   logic [LEN_W-1:0]  lstep_prev;
   logic [BITS_W-1:0] bits_cmp;
   logic [WIN_W-1:0]  diff;
   logic [IDX_W-1:0]  idx_sum;
   logic [ADDR_W-1:0] dec_addr;

   assign count_room = (count_ff < CNT_W'(MAX_SYMBOLS));

   // A scan walks the loaded lengths once, one read per cycle.
   assign scan_run   = cmd.hist_run | cmd.fill_run;
   assign scan_issue = scan_run && (scan_ff != count_ff);
   assign rd_addr    = scan_ff[ADDR_W-1:0];

   // Length store: written by load words, read by both build scans.
   always_ff @(posedge clock) begin
      if (cmd.load_wr && count_room) begin
         len_mem[count_ff[ADDR_W-1:0]] <= req_code_length;
      end
      if (scan_issue) begin
         len_rd_ff <= len_mem[rd_addr];
         sidx_ff   <= scan_ff;
      end
   end

   // The counting scan clears the used part of the symbol store; the fill scan
   // places each symbol. A fill position stays below the loaded count, so it
   // always lands inside the store.
   assign fill_wr = cmd.fill_run && rd_vld_ff && (len_rd_ff != '0);

   always_comb begin
      sym_we = 1'b0;
      sym_wa = rd_addr;
      sym_wd = '0;
      if (cmd.hist_run && scan_issue) begin
         sym_we = 1'b1;
      end else if (fill_wr) begin
         sym_we = 1'b1;
         sym_wa = next_pos_ff[len_rd_ff][ADDR_W-1:0];
         sym_wd = SYM_W'(sidx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[sym_wa] <= sym_wd;
      end
      if (cmd.dec_idx) begin
         sym_rd_ff <= sym_mem[dec_addr];
      end
   end

   // One limit step: double the running code count, left-align it, saturate.
   assign lstep_prev = lstep_ff - LEN_W'(1);
   assign acc_sum    = acc_ff + ACC_W'(hist_ff[lstep_ff]);
   assign acc_next   = {acc_sum[ACC_W-2:0], 1'b0};
   assign lim_wide   = WIDE_W'(acc_next) << (LEN_W'(MAX_LEN) - lstep_ff);
   assign lim_val    = (lim_wide > WIDE_W'(LIMIT_SAT)) ? LIMIT_SAT : lim_wide[WIN_W-1:0];
   assign base_new   = base_ff[lstep_prev] + hist_ff[lstep_prev];

   // Code length search: the shortest length whose limit lies above the peek.
   always_comb begin
      bits_cmp = BITS_W'(MAX_LEN);
      for (int i = MAX_LEN - 1; i >= 1; i--) begin
         if (peek_ff < limit_ff[i]) begin
            bits_cmp = BITS_W'(i);
         end
      end
   end

   // Offset inside the length class, then the sorted position.
   assign diff     = peek_ff - limit_ff[bits_ff - BITS_W'(1)];
   assign idx_sum  = IDX_W'(base_ff[bits_ff]) + IDX_W'(ofs_ff);
   assign dec_addr = (idx_sum >= IDX_W'(table_size_ff)) ? '0 : idx_sum[ADDR_W-1:0];

   // Next values of the control and table registers.
   always_comb begin
      count_in      = count_ff;
      table_size_in = table_size_ff;
      scan_in       = scan_ff;
      rd_vld_in     = scan_issue;
      acc_in        = acc_ff;
      lstep_in      = lstep_ff;
      hist_in       = hist_ff;
      limit_in      = limit_ff;
      base_in       = base_ff;
      next_pos_in   = next_pos_ff;

      if (cmd.load_wr && count_room) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.out_build) begin
         table_size_in = count_ff;
         count_in      = '0;
      end

      if (cmd.scan_clr) begin
         scan_in   = '0;
         rd_vld_in = 1'b0;
      end else if (scan_issue) begin
         scan_in = scan_ff + CNT_W'(1);
      end

      if (cmd.hist_clr) begin
         for (int i = 0; i < NUM_LEN; i++) begin
            hist_in[i] = '0;
         end
      end else if (cmd.hist_run && rd_vld_ff && (len_rd_ff != '0)) begin
         hist_in[len_rd_ff] = hist_ff[len_rd_ff] + CNT_W'(1);
      end

      if (cmd.lim_start) begin
         acc_in   = '0;
         lstep_in = LEN_W'(1);
      end else if (cmd.lim_run) begin
         acc_in                = acc_next;
         lstep_in              = lstep_ff + LEN_W'(1);
         limit_in[lstep_ff]    = lim_val;
         base_in[lstep_ff]     = base_new;
         next_pos_in[lstep_ff] = base_new;
      end

      if (fill_wr) begin
         next_pos_in[len_rd_ff] = next_pos_ff[len_rd_ff] + CNT_W'(1);
      end
   end

   // Result register, free again once its word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_sym || cmd.out_build) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Registers with reset. Limits reset to zero so that a decode before any
   // build picks length 15.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         table_size_ff <= '0;
         scan_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         acc_ff        <= '0;
         lstep_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_LEN; i++) begin
            hist_ff[i]  <= '0;
            limit_ff[i] <= '0;
            base_ff[i]  <= '0;
         end
      end else begin
         count_ff      <= count_in;
         table_size_ff <= table_size_in;
         scan_ff       <= scan_in;
         rd_vld_ff     <= rd_vld_in;
         acc_ff        <= acc_in;
         lstep_ff      <= lstep_in;
         rsp_valid_ff  <= rsp_valid_in;
         hist_ff       <= hist_in;
         limit_ff      <= limit_in;
         base_ff       <= base_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      next_pos_ff <= next_pos_in;
      if (cmd.peek_ld) begin
         peek_ff <= req_bit_window & PEEK_MASK;
      end
      if (cmd.dec_cmp) begin
         bits_ff <= bits_cmp;
      end
      if (cmd.dec_ofs) begin
         ofs_ff <= OFS_W'(diff >> (SHF_W'(WIN_W) - SHF_W'(bits_ff)));
      end
      if (cmd.out_sym) begin
         rsp_kind_ff   <= KIND_SYMBOL;
         // Before the first build every index selects entry 0, and the symbol is forced to zero.
         rsp_symbol_ff <= (table_size_ff == '0) ? '0 : sym_rd_ff;
         rsp_bits_ff   <= bits_ff;
      end else if (cmd.out_build) begin
         rsp_kind_ff   <= KIND_BUILD;
         rsp_symbol_ff <= '0;
         rsp_bits_ff   <= '0;
      end
   end

   assign status.scan_done = scan_run && (scan_ff == count_ff) && !rd_vld_ff;
   assign status.lim_done  = cmd.lim_run && (lstep_ff == LEN_W'(MAX_LEN));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_symbol      = rsp_symbol_ff;
   assign rsp_code_bits   = rsp_bits_ff;

endmodule

[sv/canonical_huffman_decoder_unit.sv]
// Canonical Huffman decoder with code lengths up to 15 bits. Load words
// deliver the code length of each symbol in order, starting at symbol 0;
// the load word marked last starts a table build and a single build word is
// returned when the tables are ready. A decode word carries a 16-bit peek of
// the stream (first bit in the MSB) and returns the symbol and the number of
// bits it consumed. One word is worked on at a time. A decode loads the peek
// in the accepting cycle, then steps through the limit compare, the offset,
// the sorted-position add with the symbol store read, and the result
// register, which waits while an earlier result is still held. A build is
// made of two passes over the length store through its single read port (a
// counting pass that also clears the used part of the symbol store, and a
// fill pass) and a 15-step limit sequencer. No clearing pass is needed after
// reset. The result register lets the block take the next word while a
// result still waits.
module canonical_huffman_decoder_unit import chd_pkg::*; #(
   parameter int MAX_SYMBOLS = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [LEN_W-1:0]  req_code_length,
   input  logic              req_last_length,
   input  logic [WIN_W-1:0]  req_bit_window,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_result_kind,
   output logic [SYM_W-1:0]  rsp_symbol,
   output logic [BITS_W-1:0] rsp_code_bits
);

   chd_cmd_type    cmd;
   chd_status_type status;

   // Sequencer.
   chd_controller u_controller (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_last_length (req_last_length),
      .status          (status),
      .cmd             (cmd)
   );

   // Stores, table build and decode path.
   chd_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_code_length (req_code_length),
      .req_bit_window  (req_bit_window),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_symbol      (rsp_symbol),
      .rsp_code_bits   (rsp_code_bits)
   );

endmodule
